@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the frame capture back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clk edge outside reset.
`define DSFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a clk edge outside reset.
`define DSFC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/dsfc_pkg.sv @@
// Shared types and constants of the serial frame capture block.
package dsfc_pkg;

    localparam int HISTORY_DEPTH_DEF = 256;
    localparam int FRAME_BYTES_DEF   = 14;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int LANES      = 3;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 4;
    localparam int LANE_MAG   = 0;
    localparam int LANE_CYAN  = 1;
    localparam int LANE_YEL   = 2;

    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_COLOR_MASK  = 3'd0,
        REG_DATA_DELAY  = 3'd1,
        REG_HALF_PERIOD = 3'd2,
        REG_LAST_DELAY  = 3'd3,
        REG_IDLE_LIMIT  = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [LANES-1:0] color_mask;
        logic [6:0]       data_delay;
        logic [6:0]       half_period;
        logic [6:0]       last_delay;
        logic [15:0]      idle_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        color_mask:  3'd7,
        data_delay:  7'd4,
        half_period: 7'd8,
        last_delay:  7'd1,
        idle_limit:  16'd64
    };

    typedef struct packed {
        logic             clk_rise;
        logic             order_hit;
        logic             last_hit;
        logic [LANES-1:0] first_bits;
        logic [LANES-1:0] second_bits;
    } event_t;

    typedef logic [LANES-1:0][BYTE_W-1:0] row_t;

endpackage

@@ rtl/core/dsfc_front.sv @@
// Front end: sample history memories, look-ahead reads and edge classification.
module dsfc_front #(
    parameter int HISTORY_DEPTH = dsfc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dsfc_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        low_channels,
    input  logic [7:0]        high_channels,
    output dsfc_pkg::event_t  ev,
    output logic              ev_valid,
    input  logic              ev_ready
);

    localparam int LAG    = HISTORY_DEPTH - 2;
    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int SEEN_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CW     = (ADDR_W > 9) ? ADDR_W : 9;

    localparam int LOW_QUAL  = 3;
    localparam int LOW_ORDER = 6;
    localparam int LOW_LAST  = 7;
    localparam int HIGH_CLK  = 0;

    typedef struct packed {
        logic                       clock;
        logic                       last_strobe;
        logic                       order_strobe;
        logic                       qual;
        logic [dsfc_pkg::LANES-1:0] colors;
    } hist_word_t;

    typedef struct packed {
        logic                       qual;
        logic [dsfc_pkg::LANES-1:0] colors;
    } data_word_t;

    hist_word_t mem_a [HISTORY_DEPTH];
    data_word_t mem_b [HISTORY_DEPTH];

    logic [ADDR_W-1:0] head_reg, head_next, wr_addr;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              accept, proc;

    hist_word_t wr_word, rd_now_reg, rd_first_reg, prev_reg;
    data_word_t wr_data, rd_second_reg, rd_last_reg, new_reg;
    data_word_t first_word, second_word, last_word;
    logic       byp_first_reg, byp_second_reg, byp_last_reg;

    logic [CW-1:0]     sum_second;
    logic [ADDR_W-1:0] back_first, back_second, back_last;
    logic [ADDR_W-1:0] addr_now, addr_first, addr_second, addr_last;

    function automatic logic [ADDR_W-1:0] back_of(input logic [CW-1:0] d);
        if (d > CW'(LAG))
            return '0;
        return ADDR_W'(CW'(LAG) - d);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ADDR_W-1:0] top,
                                                  input logic [ADDR_W-1:0] back);
        logic [ADDR_W:0] wide;
        if (top >= back)
            wide = {1'b0, top} - {1'b0, back};
        else
            wide = {1'b0, top} + (ADDR_W+1)'(HISTORY_DEPTH) - {1'b0, back};
        return wide[ADDR_W-1:0];
    endfunction

    assign accept   = in_valid && in_ready;
    assign in_ready = !s1_valid_reg || ev_ready;
    assign ev_valid = s1_valid_reg;
    assign proc     = (seen_reg >= SEEN_W'(HISTORY_DEPTH - 1));

    always_comb
    begin
        wr_word = '{
            clock:        high_channels[HIGH_CLK],
            last_strobe:  low_channels[LOW_LAST],
            order_strobe: low_channels[LOW_ORDER],
            qual:         low_channels[LOW_QUAL],
            colors:       low_channels[dsfc_pkg::LANES-1:0]
        };
        wr_data = '{qual: wr_word.qual, colors: wr_word.colors};
    end

    always_comb
    begin
        wr_addr    = (head_reg == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        head_next  = accept ? wr_addr : head_reg;
        seen_next  = seen_reg;
        if (accept && seen_reg != SEEN_W'(HISTORY_DEPTH))
            seen_next = seen_reg + 1'b1;

        sum_second  = CW'(cfg.data_delay) + CW'(cfg.half_period);
        back_first  = back_of(CW'(cfg.data_delay));
        back_second = back_of(sum_second);
        back_last   = back_of(CW'(cfg.last_delay));

        addr_now    = addr_of(wr_addr, ADDR_W'(LAG));
        addr_first  = addr_of(wr_addr, back_first);
        addr_second = addr_of(wr_addr, back_second);
        addr_last   = addr_of(wr_addr, back_last);
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_valid_reg && ev_ready)
            s1_valid_next = 1'b0;
        if (accept)
            s1_valid_next = proc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg     <= head_next;
            seen_reg     <= seen_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_a[wr_addr] <= wr_word;
            mem_b[wr_addr] <= wr_data;
            rd_now_reg     <= mem_a[addr_now];
            rd_first_reg   <= mem_a[addr_first];
            rd_second_reg  <= mem_b[addr_second];
            rd_last_reg    <= mem_b[addr_last];
            prev_reg       <= rd_now_reg;
            new_reg        <= wr_data;
            byp_first_reg  <= (back_first == '0);
            byp_second_reg <= (back_second == '0);
            byp_last_reg   <= (back_last == '0);
        end
    end

    always_comb
    begin
        if (byp_first_reg)
            first_word = new_reg;
        else
            first_word = '{qual: rd_first_reg.qual, colors: rd_first_reg.colors};
        second_word = byp_second_reg ? new_reg : rd_second_reg;
        last_word   = byp_last_reg ? new_reg : rd_last_reg;

        ev.clk_rise    = !prev_reg.clock && rd_now_reg.clock;
        ev.order_hit   = !prev_reg.order_strobe && rd_now_reg.order_strobe && first_word.qual;
        ev.last_hit    = !prev_reg.last_strobe && rd_now_reg.last_strobe && last_word.qual;
        ev.first_bits  = first_word.colors | ~cfg.color_mask;
        ev.second_bits = second_word.colors | ~cfg.color_mask;
    end

endmodule

@@ rtl/core/dsfc_queue.sv @@
// Short event queue between the front end and the frame builder.
module dsfc_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  dsfc_pkg::event_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output dsfc_pkg::event_t pop_data
);

    localparam int PTR_W = dsfc_pkg::QUEUE_PTR_W;
    localparam int CNT_W = PTR_W + 1;

    dsfc_pkg::event_t slots [dsfc_pkg::QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(dsfc_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slots[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_data;
    end

endmodule

@@ rtl/core/dsfc_back.sv @@
// Back end: bit counting, frame rows, frame close and byte output.
`include "assert_macros.svh"

module dsfc_back #(
    parameter int FRAME_BYTES = dsfc_pkg::FRAME_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [15:0]                  idle_limit,
    input  dsfc_pkg::event_t             ev,
    input  logic                         ev_valid,
    output logic                         ev_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dsfc_pkg::INDEX_W-1:0] byte_index,
    output logic [dsfc_pkg::BYTE_W-1:0]  magenta_byte,
    output logic [dsfc_pkg::BYTE_W-1:0]  cyan_byte,
    output logic [dsfc_pkg::BYTE_W-1:0]  yellow_byte,
    output logic                         alternate_order,
    output logic                         last
);

    localparam int FRAME_BITS = FRAME_BYTES * 8;
    localparam int BC_W       = $clog2(FRAME_BITS + 1);
    localparam int ROW_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

    dsfc_pkg::row_t rows_reg [FRAME_BYTES];
    dsfc_pkg::row_t rows_next [FRAME_BYTES];
    dsfc_pkg::row_t obuf_reg [FRAME_BYTES];

    logic [BC_W-1:0]  bit_count_reg, bit_count_next, bc_added;
    logic             last_flag_reg, last_flag_next;
    logic [1:0]       order_count_reg, order_count_next;
    logic [15:0]      idle_count_reg, idle_count_next;
    logic             busy_reg, busy_next;
    logic [ROW_W-1:0] rd_idx_reg, rd_idx_next, row_sel;
    logic             out_valid_reg, out_valid_next;
    logic             obuf_alt_reg;
    logic [2:0]       pos_a, pos_b;
    logic             can_write, close, emit, stall, pop, load, at_end;

    assign row_sel = ROW_W'(bit_count_reg >> 3);
    assign pos_a   = {bit_count_reg[2:1], 1'b0};
    assign pos_b   = {bit_count_reg[2:1], 1'b1};

    always_comb
    begin
        can_write = ev.clk_rise && (bit_count_reg < BC_W'(FRAME_BITS));
        bc_added  = can_write ? bit_count_reg + BC_W'(2) : bit_count_reg;
        close     = ev.clk_rise && (bc_added[2:0] == 3'd0) && last_flag_reg;
        emit      = close && (bc_added == BC_W'(FRAME_BITS));
        stall     = emit && busy_reg;
        pop       = ev_valid && !stall;
        load      = busy_reg && (!out_valid_reg || out_ready);
        at_end    = (rd_idx_reg == ROW_W'(FRAME_BYTES - 1));
    end

    assign ev_ready = !stall;

    always_comb
    begin
        rows_next = rows_reg;
        if (pop && can_write)
        begin
            rows_next[row_sel][dsfc_pkg::LANE_MAG][pos_a]  = ev.first_bits[dsfc_pkg::LANE_MAG];
            rows_next[row_sel][dsfc_pkg::LANE_MAG][pos_b]  = ev.second_bits[dsfc_pkg::LANE_MAG];
            rows_next[row_sel][dsfc_pkg::LANE_CYAN][pos_a] = ev.first_bits[dsfc_pkg::LANE_CYAN];
            rows_next[row_sel][dsfc_pkg::LANE_CYAN][pos_b] = ev.second_bits[dsfc_pkg::LANE_CYAN];
            rows_next[row_sel][dsfc_pkg::LANE_YEL][pos_a]  = ev.first_bits[dsfc_pkg::LANE_YEL];
            rows_next[row_sel][dsfc_pkg::LANE_YEL][pos_b]  = ev.second_bits[dsfc_pkg::LANE_YEL];
        end
    end

    always_comb
    begin
        bit_count_next   = bit_count_reg;
        last_flag_next   = last_flag_reg;
        order_count_next = order_count_reg;
        idle_count_next  = idle_count_reg;
        if (pop)
        begin
            if (ev.clk_rise)
            begin
                idle_count_next = '0;
                bit_count_next  = bc_added;
                if (close)
                begin
                    bit_count_next   = '0;
                    last_flag_next   = 1'b0;
                    order_count_next = '0;
                end
            end
            if (ev.order_hit && order_count_next != 2'd3)
                order_count_next = order_count_next + 2'd1;
            if (ev.last_hit)
                last_flag_next = 1'b1;
            if (idle_count_next > idle_limit)
                bit_count_next = {bit_count_next[BC_W-1:3], 3'b000};
            if (idle_count_next != '1)
                idle_count_next = idle_count_next + 16'd1;
        end
    end

    always_comb
    begin
        busy_next      = busy_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            rd_idx_next    = at_end ? '0 : rd_idx_reg + 1'b1;
            if (at_end)
                busy_next = 1'b0;
        end
        if (pop && emit)
            busy_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_count_reg   <= '0;
            last_flag_reg   <= 1'b0;
            order_count_reg <= '0;
            idle_count_reg  <= '0;
            busy_reg        <= 1'b0;
            rd_idx_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            bit_count_reg   <= bit_count_next;
            last_flag_reg   <= last_flag_next;
            order_count_reg <= order_count_next;
            idle_count_reg  <= idle_count_next;
            busy_reg        <= busy_next;
            rd_idx_reg      <= rd_idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rows_reg <= rows_next;
        if (pop && emit)
        begin
            obuf_reg     <= rows_next;
            obuf_alt_reg <= (order_count_reg == 2'd3);
        end
        if (load)
        begin
            byte_index      <= dsfc_pkg::INDEX_W'(rd_idx_reg);
            magenta_byte    <= obuf_reg[rd_idx_reg][dsfc_pkg::LANE_MAG];
            cyan_byte       <= obuf_reg[rd_idx_reg][dsfc_pkg::LANE_CYAN];
            yellow_byte     <= obuf_reg[rd_idx_reg][dsfc_pkg::LANE_YEL];
            alternate_order <= obuf_alt_reg;
            last            <= at_end;
        end
    end

    assign out_valid = out_valid_reg;

    `DSFC_ASSERT(a_close_clears_count, pop && close |=> bit_count_reg == '0 && order_count_reg <= 2'd1, "frame close left bit count or order count set")
    `DSFC_ASSERT(a_drain_starts_at_zero, $rose(busy_reg) |-> rd_idx_reg == '0 && $past(emit), "frame drain did not start at byte zero")
    `DSFC_ASSERT(a_final_load_frees, load && at_end |=> !busy_reg && out_valid_reg, "final byte load did not free the frame buffer")

endmodule

@@ rtl/core/ddr_serial_frame_capture.sv @@
// Top level: configuration registers, front end, event queue and frame back end.
// Throughput: one sample per cycle; input stalls only if a frame closes while the previous
//   frame's FRAME_BYTES bytes are still waiting in the output buffer.
// Output: a closing clock edge is processed HISTORY_DEPTH-2 samples later and passes the
//   front end, queue and frame buffer; then one byte per cycle while out_ready is high.
// Reset: control state clears asynchronously; the history memory is not cleared, the first
//   HISTORY_DEPTH-1 samples fill it before any edge is classified.
module ddr_serial_frame_capture #(
    parameter int HISTORY_DEPTH = dsfc_pkg::HISTORY_DEPTH_DEF,
    parameter int FRAME_BYTES   = dsfc_pkg::FRAME_BYTES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [dsfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dsfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       low_channels,
    input  logic [7:0]                       high_channels,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [dsfc_pkg::INDEX_W-1:0]     byte_index,
    output logic [dsfc_pkg::BYTE_W-1:0]      magenta_byte,
    output logic [dsfc_pkg::BYTE_W-1:0]      cyan_byte,
    output logic [dsfc_pkg::BYTE_W-1:0]      yellow_byte,
    output logic                             alternate_order,
    output logic                             last
);

    dsfc_pkg::cfg_t   cfg_reg, cfg_next;
    dsfc_pkg::event_t front_ev, back_ev;
    logic             front_valid, front_ready, back_valid, back_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (dsfc_pkg::cfg_reg_t'(cfg_index))
                dsfc_pkg::REG_COLOR_MASK:  cfg_next.color_mask  = cfg_data[2:0];
                dsfc_pkg::REG_DATA_DELAY:  cfg_next.data_delay  = cfg_data[6:0];
                dsfc_pkg::REG_HALF_PERIOD: cfg_next.half_period = cfg_data[6:0];
                dsfc_pkg::REG_LAST_DELAY:  cfg_next.last_delay  = cfg_data[6:0];
                dsfc_pkg::REG_IDLE_LIMIT:  cfg_next.idle_limit  = cfg_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= dsfc_pkg::CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    dsfc_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .low_channels  (low_channels),
        .high_channels (high_channels),
        .ev            (front_ev),
        .ev_valid      (front_valid),
        .ev_ready      (front_ready)
    );

    dsfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_ev),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_ev)
    );

    dsfc_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .idle_limit      (cfg_reg.idle_limit),
        .ev              (back_ev),
        .ev_valid        (back_valid),
        .ev_ready        (back_ready),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .byte_index      (byte_index),
        .magenta_byte    (magenta_byte),
        .cyan_byte       (cyan_byte),
        .yellow_byte     (yellow_byte),
        .alternate_order (alternate_order),
        .last            (last)
    );

endmodule

@@ tb/tb_ddr_serial_frame_capture.sv @@
// Self-checking testbench for the serial frame capture block, checked byte by byte.
`timescale 1ns / 100ps

module tb_ddr_serial_frame_capture;

    localparam int HIST        = dsfc_pkg::HISTORY_DEPTH_DEF;
    localparam int FRAME_LEN   = dsfc_pkg::FRAME_BYTES_DEF;
    localparam int LAG         = HIST - 2;
    localparam int FRAME_BITS  = FRAME_LEN * 8;
    localparam int IDLE_MAX    = 65535;
    localparam int FLUSH_LEN   = HIST + 4;
    localparam int DRAIN_PAD   = 40;
    localparam int CYCLE_LIMIT = 400000;

    localparam int LINE_QUAL  = 3;
    localparam int LINE_ORDER = 6;
    localparam int LINE_LAST  = 7;
    localparam int LINE_CLK   = 8;

    typedef struct {
        logic [dsfc_pkg::INDEX_W-1:0] index;
        logic [dsfc_pkg::BYTE_W-1:0]  magenta;
        logic [dsfc_pkg::BYTE_W-1:0]  cyan;
        logic [dsfc_pkg::BYTE_W-1:0]  yellow;
        logic                         alt_seen;
        logic                         frame_end;
    } frame_byte_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write_en;
    logic [dsfc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [dsfc_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [7:0]                       low_channels;
    logic [7:0]                       high_channels;
    logic                             out_valid;
    logic                             out_ready;
    logic [dsfc_pkg::INDEX_W-1:0]     byte_index;
    logic [dsfc_pkg::BYTE_W-1:0]      magenta_byte;
    logic [dsfc_pkg::BYTE_W-1:0]      cyan_byte;
    logic [dsfc_pkg::BYTE_W-1:0]      yellow_byte;
    logic                             alternate_order;
    logic                             last;

    ddr_serial_frame_capture u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .low_channels    (low_channels),
        .high_channels   (high_channels),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .byte_index      (byte_index),
        .magenta_byte    (magenta_byte),
        .cyan_byte       (cyan_byte),
        .yellow_byte     (yellow_byte),
        .alternate_order (alternate_order),
        .last            (last)
    );

    dsfc_pkg::cfg_t cfg_now;
    logic [15:0]    history [HIST];
    int             hist_head;
    logic [7:0]     lane_store [dsfc_pkg::LANES][FRAME_LEN];
    int             frame_bit_count;
    bit             last_byte_armed;
    int             order_hits;
    int             idle_run;
    int             samples_seen;
    frame_byte_t    frame_bytes_due [$];
    int             bytes_predicted;
    int             items_sent;
    int             mismatches;
    int unsigned    cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit take_break();
        return (cycle_count % 1600) >= 500 && $urandom_range(99) < 12;
    endfunction

    function automatic void reset_predictor();
        for (int i = 0; i < HIST; i++)
        begin
            history[i] = '0;
        end
        for (int c = 0; c < dsfc_pkg::LANES; c++)
        begin
            for (int k = 0; k < FRAME_LEN; k++)
            begin
                lane_store[c][k] = '0;
            end
        end
        hist_head       = 0;
        frame_bit_count = 0;
        last_byte_armed = 1'b0;
        order_hits      = 0;
        idle_run        = 0;
        samples_seen    = 0;
        cfg_now         = dsfc_pkg::CFG_RESET;
    endfunction

    function automatic logic line_at(int k, int b);
        return history[(hist_head + 2 * HIST - LAG + k) % HIST][b];
    endfunction

    function automatic bit rises(int b);
        return !line_at(-1, b) && line_at(0, b);
    endfunction

    function automatic int clamp_lag(int d);
        return (d > LAG) ? LAG : d;
    endfunction

    function automatic void put_frame_bit(int lane, int pos, logic v);
        lane_store[lane][pos / 8][pos % 8] = v;
    endfunction

    function automatic void advance_capture(logic [7:0] lo, logic [7:0] hi);
        int          d1;
        int          d2;
        int          dl;
        logic        on;
        frame_byte_t fb;
        d1 = clamp_lag(int'(cfg_now.data_delay));
        d2 = clamp_lag(int'(cfg_now.data_delay) + int'(cfg_now.half_period));
        dl = clamp_lag(int'(cfg_now.last_delay));
        hist_head = (hist_head + 1) % HIST;
        history[hist_head] = {hi, lo};
        if (samples_seen < HIST)
        begin
            samples_seen++;
        end
        if (samples_seen < HIST)
        begin
            return;
        end
        if (rises(LINE_CLK))
        begin
            idle_run = 0;
            if (frame_bit_count < FRAME_BITS)
            begin
                for (int c = 0; c < dsfc_pkg::LANES; c++)
                begin
                    on = cfg_now.color_mask[c];
                    put_frame_bit(c, frame_bit_count, on ? line_at(d1, c) : 1'b1);
                    put_frame_bit(c, frame_bit_count + 1, on ? line_at(d2, c) : 1'b1);
                end
                frame_bit_count += 2;
                if (frame_bit_count > FRAME_BITS)
                begin
                    frame_bit_count = FRAME_BITS;
                end
            end
            if (frame_bit_count % 8 == 0 && last_byte_armed)
            begin
                if (frame_bit_count == FRAME_BITS)
                begin
                    for (int k = 0; k < FRAME_LEN; k++)
                    begin
                        fb.index     = dsfc_pkg::INDEX_W'(k);
                        fb.magenta   = lane_store[dsfc_pkg::LANE_MAG][k];
                        fb.cyan      = lane_store[dsfc_pkg::LANE_CYAN][k];
                        fb.yellow    = lane_store[dsfc_pkg::LANE_YEL][k];
                        fb.alt_seen  = order_hits > 2;
                        fb.frame_end = (k == FRAME_LEN - 1);
                        frame_bytes_due.push_back(fb);
                        bytes_predicted++;
                    end
                end
                frame_bit_count = 0;
                last_byte_armed = 1'b0;
                order_hits      = 0;
            end
        end
        if (rises(LINE_ORDER) && line_at(d1, LINE_QUAL) && order_hits < 3)
        begin
            order_hits++;
        end
        if (rises(LINE_LAST) && line_at(dl, LINE_QUAL))
        begin
            last_byte_armed = 1'b1;
        end
        if (idle_run > int'(cfg_now.idle_limit))
        begin
            frame_bit_count = frame_bit_count & ~7;
        end
        if (idle_run < IDLE_MAX)
        begin
            idle_run++;
        end
    endfunction

    task automatic send_sample(input logic [7:0] lo, input logic [7:0] hi);
        if (take_break())
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while (take_break());
        end
        in_valid      <= 1'b1;
        low_channels  <= lo;
        high_channels <= hi;
        do @(posedge clk); while (!in_ready);
        advance_capture(lo, hi);
        items_sent++;
    endtask

    task automatic send_line_state(input bit clk_lvl, input bit order_strobe,
                                   input bit last_strobe, input int qual_pct);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'($urandom);
        hi = 8'($urandom);
        lo[LINE_QUAL]      = ($urandom_range(99) < qual_pct);
        lo[LINE_ORDER]     = order_strobe;
        lo[LINE_LAST]      = last_strobe;
        hi[LINE_CLK - 8]   = clk_lvl;
        send_sample(lo, hi);
    endtask

    task automatic send_clocks(input int rise_total, input int last_rise, input int order_n,
                               input int qual_pct, input int max_half);
        int low_len;
        int high_len;
        for (int r = 0; r < rise_total; r++)
        begin
            low_len  = $urandom_range(1, max_half);
            high_len = $urandom_range(1, max_half);
            repeat (low_len) send_line_state(1'b0, 1'b0, 1'b0, qual_pct);
            repeat (high_len) send_line_state(1'b1, (r % 2 == 1) && (r < 2 * order_n),
                                              r == last_rise, qual_pct);
        end
    endtask

    task automatic send_frame(input int order_n, input int max_half, input int qual_pct);
        int rise_total;
        rise_total = 60 + $urandom_range(0, 4);
        send_clocks(rise_total, rise_total - 2, order_n, qual_pct, max_half);
    endtask

    task automatic send_quiet(input int count);
        repeat (count) send_line_state(1'b0, 1'b0, 1'b0, 50);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (frame_bytes_due.size() != 0) @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input dsfc_pkg::cfg_reg_t r,
                             input logic [dsfc_pkg::CFG_DATA_W-1:0] v);
        cfg_write_en <= 1'b1;
        cfg_index    <= r;
        cfg_data     <= v;
        @(posedge clk);
    endtask

    task automatic apply_settings(input dsfc_pkg::cfg_t c);
        write_reg(dsfc_pkg::REG_COLOR_MASK, dsfc_pkg::CFG_DATA_W'(c.color_mask));
        write_reg(dsfc_pkg::REG_DATA_DELAY, dsfc_pkg::CFG_DATA_W'(c.data_delay));
        write_reg(dsfc_pkg::REG_HALF_PERIOD, dsfc_pkg::CFG_DATA_W'(c.half_period));
        write_reg(dsfc_pkg::REG_LAST_DELAY, dsfc_pkg::CFG_DATA_W'(c.last_delay));
        write_reg(dsfc_pkg::REG_IDLE_LIMIT, dsfc_pkg::CFG_DATA_W'(c.idle_limit));
        cfg_write_en <= 1'b0;
        cfg_now = c;
    endtask

    function automatic logic [6:0] pick_delay();
        case ($urandom_range(9))
            0:       return 7'd0;
            1:       return 7'd127;
            default: return 7'($urandom_range(0, 24));
        endcase
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic test_startup_and_extremes();
        send_sample(8'h00, 8'h00);
        send_sample(8'hff, 8'hff);
        send_sample(8'h00, 8'h00);
        send_frame(3, 2, 97);
        send_quiet(FLUSH_LEN);
        drain();
    endtask

    task automatic test_settings_extremes();
        apply_settings('{color_mask: 3'd0, data_delay: 7'd0, half_period: 7'd0,
                         last_delay: 7'd0, idle_limit: 16'hffff});
        send_frame(1, 3, 97);
        send_quiet(FLUSH_LEN);
        drain();
        apply_settings('{color_mask: 3'd5, data_delay: 7'd127, half_period: 7'd127,
                         last_delay: 7'd127, idle_limit: 16'd64});
        send_frame(4, 2, 100);
        send_quiet(FLUSH_LEN);
        drain();
        apply_settings('{color_mask: 3'd2, data_delay: 7'd4, half_period: 7'd8,
                         last_delay: 7'd1, idle_limit: 16'd16});
        send_frame(2, 3, 97);
        send_quiet(FLUSH_LEN);
        drain();
    endtask

    task automatic test_frame_overflow();
        send_clocks(72, 70, 4, 97, 2);
        send_quiet(FLUSH_LEN);
        drain();
    endtask

    task automatic test_early_last_strobe();
        send_clocks(20, 9, 0, 100, 2);
        send_frame(0, 2, 100);
        send_quiet(FLUSH_LEN);
        drain();
    endtask

    task automatic test_qualifier_low();
        send_clocks(62, 60, 3, 0, 2);
        send_frame(3, 2, 100);
        send_quiet(FLUSH_LEN);
        drain();
    endtask

    task automatic test_idle_realign();
        apply_settings('{color_mask: 3'd7, data_delay: 7'd4, half_period: 7'd8,
                         last_delay: 7'd1, idle_limit: 16'd3});
        send_clocks(9, -1, 0, 100, 1);
        send_quiet(8);
        send_frame(1, 1, 100);
        send_quiet(FLUSH_LEN);
        drain();
    endtask

    task automatic test_random_traffic();
        dsfc_pkg::cfg_t c;
        int             roll;
        int             items_at_start;
        int             bytes_at_start;
        int             phases;
        items_at_start = items_sent;
        bytes_at_start = bytes_predicted;
        phases = 0;
        while ((items_sent - items_at_start < 280 || bytes_predicted - bytes_at_start < 56)
               && phases < 16)
        begin
            c.color_mask  = 3'($urandom_range(0, 7));
            c.data_delay  = pick_delay();
            c.half_period = pick_delay();
            c.last_delay  = pick_delay();
            roll = $urandom_range(9);
            c.idle_limit  = (roll == 0) ? 16'd0 :
                            (roll == 1) ? 16'hffff : 16'($urandom_range(16, 400));
            apply_settings(c);
            repeat ($urandom_range(2, 4))
            begin
                roll = $urandom_range(99);
                if (roll < 70)
                begin
                    send_frame($urandom_range(0, 4), $urandom_range(1, 3), 97);
                end
                else if (roll < 85)
                begin
                    send_clocks($urandom_range(4, 40), $urandom_range(0, 48),
                                $urandom_range(0, 3), 60, 3);
                end
                else
                begin
                    repeat ($urandom_range(10, 60)) send_sample(8'($urandom), 8'($urandom));
                end
            end
            send_quiet(FLUSH_LEN);
            drain();
            phases++;
        end
    endtask

    initial
    begin : frame_sink
        frame_byte_t due;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $error("frame byte %0d arrived with none due", byte_index);
                    mismatches++;
                end
                else
                begin
                    due = frame_bytes_due.pop_front();
                    check_field("byte_index", due.index, byte_index);
                    check_field("magenta_byte", due.magenta, magenta_byte);
                    check_field("cyan_byte", due.cyan, cyan_byte);
                    check_field("yellow_byte", due.yellow, yellow_byte);
                    check_field("alternate_order", due.alt_seen, alternate_order);
                    check_field("last", due.frame_end, last);
                end
            end
            out_ready <= !take_break();
        end
    end

    initial
    begin
        mismatches      = 0;
        items_sent      = 0;
        bytes_predicted = 0;
        rst_n         <= 1'b0;
        cfg_write_en  <= 1'b0;
        cfg_index     <= dsfc_pkg::REG_COLOR_MASK;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        low_channels  <= '0;
        high_channels <= '0;
        reset_predictor();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_startup_and_extremes();
        test_settings_extremes();
        test_frame_overflow();
        test_early_last_strobe();
        test_qualifier_low();
        test_idle_realign();
        test_random_traffic();

        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
